[rtl/ewse_pkg.sv]
// ----------------------------------------------------------------------------
// ewse_pkg
// Shared constants for the encoder window speed estimator: ring geometry,
// datapath widths, register indexes, operation codes, reset values and saturation limits.
// ----------------------------------------------------------------------------
`default_nettype none

package ewse_pkg;

	// ring geometry
	localparam int RING_DEPTH = 16;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	// datapath widths
	localparam int DATA_W    = 32;
	localparam int TICK_W    = 16;
	localparam int ALU_W     = DATA_W + 2;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int DIV_CNT_W = $clog2(DATA_W);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_TICKS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = CFG_IDX_W'(1);

	localparam logic [TICK_W-1:0] MIN_TICKS_RST   = TICK_W'(4);
	localparam logic [DATA_W-1:0] SPEED_SCALE_RST = DATA_W'(411774832);

	// item operation codes
	localparam logic OP_RECORD  = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	// saturation limits of the signed Q16.16 speed
	localparam logic [DATA_W-1:0] SPEED_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SPEED_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

[rtl/ewse_if.sv]
// ----------------------------------------------------------------------------
// ewse interfaces
// Valid/ready channels of the estimator: command items in, speed items out.
// ----------------------------------------------------------------------------
`default_nettype none

// command item: record a sample or ask for a speed estimate
interface ewse_cmd_if import ewse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic signed [DATA_W-1:0] position;
	logic        [DATA_W-1:0] time_ms;

	modport source (output valid, op, position, time_ms, input ready);
	modport sink   (input valid, op, position, time_ms, output ready);
endinterface

// speed item
interface ewse_est_if import ewse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] speed;
	logic                     zero_interval;
	logic                     saturated;

	modport source (output valid, speed, zero_interval, saturated, input ready);
	modport sink   (input valid, speed, zero_interval, saturated, output ready);
endinterface

`default_nettype wire

[rtl/encoder_window_speed_estimator.sv]
// Record item: written to the ring when accepted; the input stays ready for the next item.
// Compute item: reads the newest sample, scans the ring for a reference, then forms ticks,
// dt, product and quotient; a zero interval skips multiply and divide, and a quotient of
// 2^32 or more skips the divide. Scan length comes from the one ring read port, the 32
// divide steps from the shared subtractor; input is ready again once the speed item is loaded,
// later if an earlier speed item is still held. Reset clears the entry valid bits at once.
// ----------------------------------------------------------------------------
// encoder_window_speed_estimator
// Ring of encoder samples with an adaptive reference search and a serial
// Q16.16 speed divide built around one shared subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_window_speed_estimator import ewse_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	ewse_cmd_if.sink                   cmd,
	ewse_est_if.source                 est
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_RDCUR  = 10'b00_0000_0010,
		ST_SCAN   = 10'b00_0000_0100,
		ST_RDREF  = 10'b00_0000_1000,
		ST_TICKS  = 10'b00_0001_0000,
		ST_DT     = 10'b00_0010_0000,
		ST_MUL    = 10'b00_0100_0000,
		ST_DIVCHK = 10'b00_1000_0000,
		ST_DIV    = 10'b01_0000_0000,
		ST_DONE   = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	logic [TICK_W-1:0] min_ticks_q;
	logic [DATA_W-1:0] scale_q;

	logic [IDX_W-1:0]      newest_q, idx_q, ref_q, newest_nxt, raddr, raddr_s1;
	logic [RING_DEPTH-1:0] vld_q;
	logic                  cmd_fire, ram_we;
	logic [2*DATA_W-1:0]   ram_rdata;
	logic [DATA_W-1:0]     ent_pos, ent_time;

	logic [ALU_W-1:0] alu_a, alu_b, alu_res, alu_abs;
	logic             alu_neg, scan_hit;

	logic [DATA_W-1:0]    pcur_q, tcur_q, tref_q, mag_q, dt_q, rem_q, lo_q;
	logic                 neg_q, zero_q, presat_q;
	logic [PROD_W-1:0]    prod_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [DATA_W-1:0] res_speed;
	logic              res_sat, res_load;

	logic [DATA_W-1:0] est_speed_q;
	logic              est_vld_q, est_zero_q, est_sat_q;

	assign cmd_fire   = cmd.valid && cmd.ready;
	assign cmd.ready  = (state_q == ST_IDLE);
	assign newest_nxt = (newest_q == IDX_W'(RING_DEPTH - 1)) ? '0 : newest_q + 1'b1;
	assign ram_we     = cmd_fire && (cmd.op == OP_RECORD);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ticks_q <= MIN_TICKS_RST;
			scale_q     <= SPEED_SCALE_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MIN_TICKS) begin
				min_ticks_q <= cfg_data[TICK_W-1:0];
			end else if (cfg_index == REG_SPEED_SCALE) begin
				scale_q <= cfg_data[DATA_W-1:0];
			end
		end
	end

	// sample ring: position in the upper half, timestamp in the lower
	ewse_ram #(
		.WIDTH (2 * DATA_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (newest_nxt),
		.wdata ({cmd.position, cmd.time_ms}),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// read address per state
	always_comb begin
		unique case (state_q)
			ST_IDLE:  raddr = newest_q;
			ST_SCAN:  raddr = idx_q + 1'b1;
			ST_RDREF: raddr = ref_q;
			default:  raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= raddr;
	end

	// unwritten entries read as position zero with their index as timestamp
	assign ent_pos  = vld_q[raddr_s1] ? ram_rdata[2*DATA_W-1:DATA_W] : '0;
	assign ent_time = vld_q[raddr_s1] ? ram_rdata[DATA_W-1:0] : DATA_W'(raddr_s1);

	// newest index and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= '0;
			vld_q    <= '0;
		end else if (ram_we) begin
			newest_q           <= newest_nxt;
			vld_q[newest_nxt]  <= 1'b1;
		end
	end

	// shared subtractor: scan distance, ticks, dt, quotient range check, divide steps
	always_comb begin
		unique case (state_q)
			ST_SCAN: begin
				alu_a = {{(ALU_W-DATA_W){ent_pos[DATA_W-1]}}, ent_pos};
				alu_b = {{(ALU_W-DATA_W){pcur_q[DATA_W-1]}}, pcur_q};
			end
			ST_TICKS: begin
				alu_a = {{(ALU_W-DATA_W){pcur_q[DATA_W-1]}}, pcur_q};
				alu_b = {{(ALU_W-DATA_W){ent_pos[DATA_W-1]}}, ent_pos};
			end
			ST_DT: begin
				alu_a = ALU_W'(tcur_q);
				alu_b = ALU_W'(tref_q);
			end
			ST_DIVCHK: begin
				alu_a = ALU_W'(prod_q[PROD_W-1:DATA_W]);
				alu_b = ALU_W'(dt_q);
			end
			ST_DIV: begin
				alu_a = ALU_W'({rem_q, lo_q[DATA_W-1]});
				alu_b = ALU_W'(dt_q);
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	assign alu_res  = alu_a - alu_b;
	assign alu_neg  = alu_res[ALU_W-1];
	assign alu_abs  = alu_neg ? ALU_W'('0 - alu_res) : alu_res;
	assign scan_hit = (alu_abs >= ALU_W'(min_ticks_q));

	// result formatting
	always_comb begin
		res_sat = !zero_q && (presat_q ||
			(lo_q[DATA_W-1] && (!neg_q || (|lo_q[DATA_W-2:0]))));
		if (zero_q) begin
			res_speed = '0;
		end else if (res_sat) begin
			res_speed = neg_q ? SPEED_MIN : SPEED_MAX;
		end else begin
			res_speed = neg_q ? DATA_W'('0 - lo_q) : lo_q;
		end
	end

	assign res_load = (state_q == ST_DONE) && (!est_vld_q || est.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			ref_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire && (cmd.op == OP_COMPUTE)) begin
						state_q <= ST_RDCUR;
					end
				end
				ST_RDCUR: begin
					idx_q   <= '0;
					ref_q   <= newest_nxt;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_hit) begin
						ref_q   <= idx_q;
						state_q <= ST_RDREF;
					end else if (idx_q == IDX_W'(RING_DEPTH - 1)) begin
						state_q <= ST_RDREF;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_RDREF:  state_q <= ST_TICKS;
				ST_TICKS:  state_q <= ST_DT;
				ST_DT: begin
					state_q <= (alu_res[DATA_W-1:0] == '0) ? ST_DONE : ST_MUL;
				end
				ST_MUL:    state_q <= ST_DIVCHK;
				ST_DIVCHK: begin
					cnt_q   <= '0;
					state_q <= alu_neg ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_RDCUR: begin
				pcur_q <= ent_pos;
				tcur_q <= ent_time;
			end
			ST_TICKS: begin
				tref_q <= ent_time;
				mag_q  <= alu_abs[DATA_W-1:0];
				neg_q  <= alu_neg;
			end
			ST_DT: begin
				dt_q   <= alu_res[DATA_W-1:0];
				zero_q <= (alu_res[DATA_W-1:0] == '0);
			end
			ST_MUL: begin
				prod_q <= PROD_W'(mag_q) * PROD_W'(scale_q);
			end
			ST_DIVCHK: begin
				// quotient of 2^32 or more cannot fit
				presat_q <= !alu_neg;
				rem_q    <= prod_q[PROD_W-1:DATA_W];
				lo_q     <= prod_q[DATA_W-1:0];
			end
			ST_DIV: begin
				// restoring step: one quotient bit shifts in per cycle
				rem_q <= alu_neg ? {rem_q[DATA_W-2:0], lo_q[DATA_W-1]}
					: alu_res[DATA_W-1:0];
				lo_q  <= {lo_q[DATA_W-2:0], !alu_neg};
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_vld_q <= 1'b0;
		end else if (res_load) begin
			est_vld_q <= 1'b1;
		end else if (est.ready) begin
			est_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			est_speed_q <= res_speed;
			est_zero_q  <= zero_q;
			est_sat_q   <= res_sat;
		end
	end

	assign est.valid         = est_vld_q;
	assign est.speed         = est_speed_q;
	assign est.zero_interval = est_zero_q;
	assign est.saturated     = est_sat_q;

	// checks
	a_compute_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && (cmd.op == OP_COMPUTE) |=> state_q == ST_RDCUR)
		else $error("compute item did not start the ring read");

	a_record_advances: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && (cmd.op == OP_RECORD) |=> newest_q != $past(newest_q))
		else $error("record item did not advance the newest index");

	a_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		est_vld_q && est_zero_q |-> (est_speed_q == '0) && !est_sat_q)
		else $error("zero interval with nonzero speed or saturation");

	a_div_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < dt_q)
		else $error("divider remainder out of range");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !est_vld_q || est.ready)
		else $error("speed item overwritten before it was taken");

endmodule

`default_nettype wire

[rtl/ewse_ram.sv]
// ----------------------------------------------------------------------------
// ewse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ewse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
